### hw/rtl/cma_pkg.sv
// Package for the confusion matrix accumulator: command and state types,
// fixed field widths and queue sizing. No dependencies.
`default_nettype none

package cma_pkg;

	localparam int NUM_CLASSES_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int KIND_W  = 2;
	localparam int CLASS_W = 4;
	localparam int OUT_W   = 32;
	localparam int FRAC_W  = 16;
	localparam int STEP_W  = $clog2(FRAC_W);

	// queue depth must stay a power of two: pointers wrap naturally
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_RECORD = 2'd0,
		KIND_ROW    = 2'd1,
		KIND_TOTAL  = 2'd2,
		KIND_CELL   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [CLASS_W-1:0] act;
		logic [CLASS_W-1:0] pred;
		logic               act_ok;
		logic               pred_ok;
	} cmd_t;

	typedef enum logic [1:0] {
		FRAC_IDLE = 2'd0,
		FRAC_DIV  = 2'd1,
		FRAC_SHOW = 2'd2
	} frac_state_t;

endpackage

`default_nettype wire

### hw/rtl/cma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cma_front.sv
// Front end: accepts input transfers, checks class ranges, drops unusable
// records and queues commands for the back end. Uses cma_pkg.
`default_nettype none

module cma_front
	import cma_pkg::*;
#(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [CLASS_W-1:0] actual_class,
	input  wire logic [CLASS_W-1:0] predicted_class,
	output logic                    q_valid,
	output cmd_t                    q_cmd,
	input  wire logic               q_pop
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cmd_in;
	logic              push;

	always_comb begin
		cmd_in.kind    = kind_t'(kind);
		cmd_in.act     = actual_class;
		cmd_in.pred    = predicted_class;
		cmd_in.act_ok  = 32'(actual_class) < NUM_CLASSES;
		cmd_in.pred_ok = 32'(predicted_class) < NUM_CLASSES;
	end

	assign in_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	// drop records outside the matrix here; they change nothing
	assign push = in_valid && in_ready &&
		!(cmd_in.kind == KIND_RECORD && !(cmd_in.act_ok && cmd_in.pred_ok));

	assign q_valid = count_q != '0;
	assign q_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cma_back.sv
// Back end: cell count RAM with read-modify-write, row and grand counters,
// and hand-off of query operands to the fraction unit. Uses cma_pkg, cma_ram.
`default_nettype none

module cma_back
	import cma_pkg::*;
#(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	input  wire cmd_t                   q_cmd,
	output logic                        q_pop,
	output logic                        job_valid,
	input  wire logic                   job_ready,
	output logic [COUNT_WIDTH-1:0]      job_tot,
	output logic [COUNT_WIDTH-1:0]      job_err,
	output logic                        job_cell
);

	// class fields are four bits, so at most sixteen rows are reachable
	localparam int USED   = (NUM_CLASSES < (1 << CLASS_W)) ? NUM_CLASSES : (1 << CLASS_W);
	localparam int RB     = $clog2(USED);
	localparam int ROWS   = 1 << RB;
	localparam int ADDR_W = 2 * RB;
	localparam int CELLS  = 1 << ADDR_W;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic              s1_done;
	logic              s1_record;
	logic [RB-1:0]     row_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [ADDR_W-1:0] rd_addr;
	cnt_t              rdata;
	cnt_t              cell_cur;
	cnt_t              cell_new;

	logic              lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	cnt_t              lw_data_q;
	logic [CELLS-1:0]  cell_vld_q;
	cnt_t              row_tot_q [ROWS];
	cnt_t              row_cor_q [ROWS];
	cnt_t              grand_tot_q;
	cnt_t              grand_cor_q;
	cnt_t              tot_sel;
	cnt_t              cor_sel;

	assign rd_addr = {q_cmd.act[RB-1:0], q_cmd.pred[RB-1:0]};
	assign row_s1  = cmd_s1.act[RB-1:0];
	assign addr_s1 = {cmd_s1.act[RB-1:0], cmd_s1.pred[RB-1:0]};

	assign s1_record = valid_s1 && cmd_s1.kind == KIND_RECORD;
	assign s1_done   = valid_s1 && (cmd_s1.kind == KIND_RECORD || job_ready);
	assign q_pop     = q_valid && (!valid_s1 || s1_done);

	cma_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (s1_record),
		.waddr(addr_s1),
		.wdata(cell_new),
		.re   (q_pop),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// the read may have raced the previous write to the same cell: forward it
	always_comb begin
		if (lw_valid_q && lw_addr_q == addr_s1) begin
			cell_cur = lw_data_q;
		end else if (cell_vld_q[addr_s1]) begin
			cell_cur = rdata;
		end else begin
			cell_cur = '0;
		end
		cell_new = sat_inc(cell_cur);
	end

	always_comb begin
		unique case (cmd_s1.kind)
			KIND_ROW: begin
				tot_sel  = cmd_s1.act_ok ? row_tot_q[row_s1] : '0;
				cor_sel  = cmd_s1.act_ok ? row_cor_q[row_s1] : '0;
				job_cell = 1'b0;
			end
			KIND_TOTAL: begin
				tot_sel  = grand_tot_q;
				cor_sel  = grand_cor_q;
				job_cell = 1'b0;
			end
			KIND_CELL: begin
				tot_sel  = (cmd_s1.act_ok && cmd_s1.pred_ok) ? cell_cur : '0;
				cor_sel  = tot_sel;
				job_cell = 1'b1;
			end
			default: begin
				tot_sel  = '0;
				cor_sel  = '0;
				job_cell = 1'b0;
			end
		endcase
		job_tot   = tot_sel;
		job_err   = tot_sel - cor_sel;
		job_valid = valid_s1 && cmd_s1.kind != KIND_RECORD;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_cmd;
		end
		if (s1_record) begin
			lw_addr_q <= addr_s1;
			lw_data_q <= cell_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			lw_valid_q  <= 1'b0;
			cell_vld_q  <= '0;
			grand_tot_q <= '0;
			grand_cor_q <= '0;
			for (int i = 0; i < ROWS; i++) begin
				row_tot_q[i] <= '0;
				row_cor_q[i] <= '0;
			end
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_record) begin
				lw_valid_q          <= 1'b1;
				cell_vld_q[addr_s1] <= 1'b1;
				row_tot_q[row_s1]   <= sat_inc(row_tot_q[row_s1]);
				grand_tot_q         <= sat_inc(grand_tot_q);
				if (cmd_s1.act == cmd_s1.pred) begin
					row_cor_q[row_s1] <= sat_inc(row_cor_q[row_s1]);
					grand_cor_q       <= sat_inc(grand_cor_q);
				end
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cma_frac.sv
// Result unit: Q0.16 error fraction by restoring division, one bit a cycle,
// and the output register. Uses cma_pkg.
`default_nettype none

module cma_frac
	import cma_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_valid,
	output logic                        job_ready,
	input  wire logic [COUNT_WIDTH-1:0] job_tot,
	input  wire logic [COUNT_WIDTH-1:0] job_err,
	input  wire logic                   job_cell,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [OUT_W-1:0]            total_count,
	output logic [OUT_W-1:0]            error_count,
	output logic [FRAC_W-1:0]           error_fraction,
	output logic                        empty_res
);

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	function automatic logic [OUT_W-1:0] clip(input cnt_t v);
		logic [63:0] e;
		e = 64'(v);
		return (e[63:OUT_W] != '0) ? '1 : e[OUT_W-1:0];
	endfunction

	frac_state_t       state_q;
	frac_state_t       state_d;
	logic              take;
	logic              needs_div;
	logic              last_step;
	logic [COUNT_WIDTH:0] rem_x2;
	logic              ge;

	cnt_t              rem_q;
	cnt_t              div_q;
	logic [FRAC_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [OUT_W-1:0]  tot_out_q;
	logic [OUT_W-1:0]  err_out_q;
	logic              empty_q;

	assign take      = job_valid && job_ready;
	assign needs_div = !job_cell && job_tot != '0 && job_err < job_tot;
	assign last_step = step_q == STEP_W'(FRAC_W - 1);

	// remainder stays below the divisor, so one extra bit holds the shift
	assign rem_x2 = {rem_q, 1'b0};
	assign ge     = rem_x2 >= {1'b0, div_q};

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			FRAC_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = needs_div ? FRAC_DIV : FRAC_SHOW;
				end
			end
			FRAC_DIV: begin
				if (last_step) begin
					state_d = FRAC_SHOW;
				end
			end
			FRAC_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = FRAC_IDLE;
				end
			end
			default: begin
				state_d = FRAC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRAC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q  <= job_err;
			div_q  <= job_tot;
			step_q <= '0;
			if (job_cell) begin
				tot_out_q <= clip(job_tot);
				err_out_q <= '0;
				quo_q     <= '0;
				empty_q   <= 1'b0;
			end else if (job_tot == '0) begin
				tot_out_q <= '0;
				err_out_q <= '0;
				quo_q     <= '0;
				empty_q   <= 1'b1;
			end else begin
				tot_out_q <= clip(job_tot);
				err_out_q <= clip(job_err);
				// a fraction of one or more saturates
				quo_q     <= needs_div ? '0 : '1;
				empty_q   <= 1'b0;
			end
		end else if (state_q == FRAC_DIV) begin
			rem_q  <= ge ? COUNT_WIDTH'(rem_x2 - {1'b0, div_q}) : COUNT_WIDTH'(rem_x2);
			quo_q  <= {quo_q[FRAC_W-2:0], ge};
			step_q <= step_q + 1'b1;
		end
	end

	assign total_count    = tot_out_q;
	assign error_count    = err_out_q;
	assign error_fraction = quo_q;
	assign empty_res      = empty_q;

endmodule

`default_nettype wire

### hw/rtl/confusion_matrix_accumulator.sv
// Confusion matrix accumulator. Each input transfer either records an
// (actual, predicted) class pair or asks a query: a row's error, the overall
// error, or one cell. Records are taken at one per cycle sustained while no
// query waits for the result unit: the back end reads the cell RAM when a
// command leaves the queue and writes the incremented count in the following
// cycle, with the last write forwarded. A query answers through the result
// unit: a cell read, an empty row or matrix, or an error of one or more goes
// straight to the output register; a true fraction first passes through the
// one-bit-a-cycle divider. A four-entry command queue separates input
// acceptance from this work, so input keeps flowing while a result waits
// for its transfer, until the queue fills. All counts are zero after reset;
// per-cell valid bits stand in for clearing the RAM, so no clearing pass is
// needed. Records with a class at or beyond NUM_CLASSES are dropped.
// Uses cma_pkg, cma_front, cma_back, cma_frac.
`default_nettype none

module confusion_matrix_accumulator
	import cma_pkg::*;
#(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [CLASS_W-1:0] actual_class,
	input  wire logic [CLASS_W-1:0] predicted_class,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [OUT_W-1:0]        total_count,
	output logic [OUT_W-1:0]        error_count,
	output logic [FRAC_W-1:0]       error_fraction,
	output logic                    empty_res
);

	logic                   q_valid;
	cmd_t                   q_cmd;
	logic                   q_pop;
	logic                   job_valid;
	logic                   job_ready;
	logic [COUNT_WIDTH-1:0] job_tot;
	logic [COUNT_WIDTH-1:0] job_err;
	logic                   job_cell;

	cma_front #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.actual_class   (actual_class),
		.predicted_class(predicted_class),
		.q_valid        (q_valid),
		.q_cmd          (q_cmd),
		.q_pop          (q_pop)
	);

	cma_back #(
		.NUM_CLASSES(NUM_CLASSES),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_tot  (job_tot),
		.job_err  (job_err),
		.job_cell (job_cell)
	);

	cma_frac #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_frac (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job_ready     (job_ready),
		.job_tot       (job_tot),
		.job_err       (job_err),
		.job_cell      (job_cell),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.total_count   (total_count),
		.error_count   (error_count),
		.error_fraction(error_fraction),
		.empty_res     (empty_res)
	);

`ifndef SYNTHESIS
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |->
			total_count == '0 && error_count == '0 && error_fraction == '0)
		else $error("empty result carries nonzero fields");

	a_err_le_tot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_count <= total_count)
		else $error("error count exceeds total count");

	a_unit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> !job_ready)
		else $error("result unit took a job while busy");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire
